/* rtl/plld_pkg.sv */
`timescale 1ns / 1ps

package plld_pkg;

    // coordinate width of one position field
    localparam int COORD_BITS = 24;

    // multiplier operand: absolute coordinate difference or threshold
    localparam int OP_W   = COORD_BITS;
    localparam int PROD_W = 2 * OP_W;
    // sum of two squares
    localparam int SQ_W   = PROD_W + 1;
    // floor square root of a SQ_W value, padded to whole bit pairs
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int ITER_W = $clog2(ROOT_W);

    localparam int THR_W   = 16;
    localparam int THRSQ_W = 2 * THR_W;
    localparam int TOTAL_W = 32;
    localparam int STEP_W  = 25;
    localparam int ROOT_EXT_W = (ROOT_W > STEP_W) ? ROOT_W : STEP_W;

    localparam logic [THR_W-1:0]   THR_RESET = 16'd100;
    localparam logic [STEP_W-1:0]  STEP_MAX  = {STEP_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_ADD,
        ST_LAP,
        ST_ROOT,
        ST_ACCUM,
        ST_DONE
    } st_t;

    // which value goes through the shared multiplier
    typedef enum logic [2:0] {
        TERM_THR,
        TERM_OX,
        TERM_OY,
        TERM_DX,
        TERM_DY
    } term_t;

endpackage

/* rtl/path_length_and_lap_detector.sv */
`timescale 1ns / 1ps

// path length and lap detector
//
// input channel: pos_x / pos_y (signed mm) with in_valid / in_stall. an item is
// taken at a clock edge with in_valid high and in_stall low. in_stall is high
// from the edge after an accept until the sequencer is back in idle.
// output channel: total_length, step_length, lap_closed, first_sample with
// out_valid / out_stall. one result item for every input item, in order.
// config: cfg_wr_en / cfg_wr_data write the lap threshold (reset 100 mm);
// write it only while no item is in flight.
//
// sequence: one shared 24x24 multiplier squares the threshold and the two
// start offsets (each through the diff, square and add states), then for a
// later sample the two step offsets; the square root is bit serial, one root
// bit per cycle. a new item is taken only once the sequencer is back in idle;
// the pace is set by the multiplier sequence and the serial root.
// a result held by out_stall stays in the output register; the next item is
// accepted and worked on meanwhile, and waits in the final state if the
// output register is still full.
// reset: asynchronous, clears the start/previous positions and the total.

module path_length_and_lap_detector
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [plld_pkg::THR_W-1:0]           cfg_wr_data,
    // input items
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [plld_pkg::COORD_BITS-1:0] pos_x,
    input  logic signed [plld_pkg::COORD_BITS-1:0] pos_y,
    // result items
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [plld_pkg::TOTAL_W-1:0]         total_length,
    output logic [plld_pkg::STEP_W-1:0]          step_length,
    output logic                                 lap_closed,
    output logic                                 first_sample
);

    // sequencer
    plld_pkg::st_t   state_reg;
    plld_pkg::st_t   state_next;
    plld_pkg::term_t term_reg;
    plld_pkg::term_t term_next;
    logic [plld_pkg::ITER_W-1:0] iter_reg;

    // persistent state
    logic [plld_pkg::THR_W-1:0]   thr_reg;
    logic                         started_reg;
    logic signed [plld_pkg::COORD_BITS-1:0] prev_x_reg;
    logic signed [plld_pkg::COORD_BITS-1:0] prev_y_reg;
    logic signed [plld_pkg::COORD_BITS-1:0] origin_x_reg;
    logic signed [plld_pkg::COORD_BITS-1:0] origin_y_reg;
    logic [plld_pkg::TOTAL_W-1:0] total_reg;

    // working registers for the current item
    logic signed [plld_pkg::COORD_BITS-1:0] cur_x_reg;
    logic signed [plld_pkg::COORD_BITS-1:0] cur_y_reg;
    logic                         first_reg;
    logic [plld_pkg::OP_W-1:0]    op_reg;
    logic [plld_pkg::PROD_W-1:0]  prod_reg;
    logic [plld_pkg::SQ_W-1:0]    acc_reg;
    logic [plld_pkg::THRSQ_W-1:0] thr_sq_reg;
    logic [plld_pkg::RAD_W-1:0]   rad_reg;
    logic [plld_pkg::REM_W-1:0]   rem_reg;
    logic [plld_pkg::ROOT_W-1:0]  root_reg;
    logic                         lap_reg;

    // output register
    logic                         out_valid_reg;
    logic [plld_pkg::TOTAL_W-1:0] total_length_reg;
    logic [plld_pkg::STEP_W-1:0]  step_length_reg;
    logic                         lap_closed_reg;
    logic                         first_sample_reg;

    // control strobes
    logic in_take;
    logic out_take;
    logic out_load;

    // datapath wires
    logic signed [plld_pkg::COORD_BITS-1:0] sel_a;
    logic signed [plld_pkg::COORD_BITS-1:0] sel_b;
    logic signed [plld_pkg::COORD_BITS:0]   diff;
    logic [plld_pkg::COORD_BITS:0]          diff_abs;
    logic [plld_pkg::SQ_W-1:0]              sq_sum;
    logic [plld_pkg::REM_W-1:0]             rem_cat;
    logic [plld_pkg::REM_W-1:0]             trial;
    logic                                   root_bit;
    logic [plld_pkg::TOTAL_W:0]             total_sum;
    logic [plld_pkg::ROOT_EXT_W-1:0]        root_ext;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plld_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = plld_pkg::ST_DIFF;
                end
            end
            plld_pkg::ST_DIFF:
            begin
                state_next = plld_pkg::ST_SQUARE;
            end
            plld_pkg::ST_SQUARE:
            begin
                state_next = plld_pkg::ST_ADD;
            end
            plld_pkg::ST_ADD:
            begin
                case (term_reg)
                    plld_pkg::TERM_OY: state_next = plld_pkg::ST_LAP;
                    plld_pkg::TERM_DY: state_next = plld_pkg::ST_ROOT;
                    default:           state_next = plld_pkg::ST_DIFF;
                endcase
            end
            plld_pkg::ST_LAP:
            begin
                state_next = first_reg ? plld_pkg::ST_DONE : plld_pkg::ST_DIFF;
            end
            plld_pkg::ST_ROOT:
            begin
                if (iter_reg == '0)
                begin
                    state_next = plld_pkg::ST_ACCUM;
                end
            end
            plld_pkg::ST_ACCUM:
            begin
                state_next = plld_pkg::ST_DONE;
            end
            plld_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = plld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plld_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_stall = (state_reg != plld_pkg::ST_IDLE);
        in_take  = in_valid && (state_reg == plld_pkg::ST_IDLE);
        out_take = out_valid_reg && !out_stall;
        out_load = (state_reg == plld_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    end

    // order of the multiplier terms
    always_comb
    begin
        case (term_reg)
            plld_pkg::TERM_THR: term_next = plld_pkg::TERM_OX;
            plld_pkg::TERM_OX:  term_next = plld_pkg::TERM_OY;
            plld_pkg::TERM_OY:  term_next = plld_pkg::TERM_DX;
            plld_pkg::TERM_DX:  term_next = plld_pkg::TERM_DY;
            default:            term_next = plld_pkg::TERM_THR;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    always_comb
    begin
        case (term_reg)
            plld_pkg::TERM_OX:
            begin
                sel_a = cur_x_reg;
                sel_b = origin_x_reg;
            end
            plld_pkg::TERM_OY:
            begin
                sel_a = cur_y_reg;
                sel_b = origin_y_reg;
            end
            plld_pkg::TERM_DX:
            begin
                sel_a = cur_x_reg;
                sel_b = prev_x_reg;
            end
            plld_pkg::TERM_DY:
            begin
                sel_a = cur_y_reg;
                sel_b = prev_y_reg;
            end
            default:
            begin
                sel_a = '0;
                sel_b = '0;
            end
        endcase
    end

    assign diff     = {sel_a[plld_pkg::COORD_BITS-1], sel_a}
                    - {sel_b[plld_pkg::COORD_BITS-1], sel_b};
    assign diff_abs = diff[plld_pkg::COORD_BITS] ? unsigned'(-diff) : unsigned'(diff);

    assign sq_sum = acc_reg + plld_pkg::SQ_W'(prod_reg);

    // one bit of the restoring square root
    assign rem_cat  = {rem_reg[plld_pkg::REM_W-3:0], rad_reg[plld_pkg::RAD_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign root_bit = (rem_cat >= trial);

    assign total_sum = {1'b0, total_reg} + (plld_pkg::TOTAL_W + 1)'(root_reg);
    assign root_ext  = plld_pkg::ROOT_EXT_W'(root_reg);

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plld_pkg::ST_IDLE;
            term_reg      <= plld_pkg::TERM_THR;
            iter_reg      <= '0;
            thr_reg       <= plld_pkg::THR_RESET;
            started_reg   <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end

            if (in_take)
            begin
                term_reg <= plld_pkg::TERM_THR;
                // first sample seeds start and previous positions
                if (!started_reg)
                begin
                    started_reg  <= 1'b1;
                    prev_x_reg   <= pos_x;
                    prev_y_reg   <= pos_y;
                    origin_x_reg <= pos_x;
                    origin_y_reg <= pos_y;
                end
            end

            if (state_reg == plld_pkg::ST_ADD || state_reg == plld_pkg::ST_LAP)
            begin
                if (state_reg == plld_pkg::ST_ADD && term_reg == plld_pkg::TERM_OY)
                begin
                    term_reg <= term_reg;
                end
                else
                begin
                    term_reg <= term_next;
                end
            end

            if (state_reg == plld_pkg::ST_ADD && term_reg == plld_pkg::TERM_DY)
            begin
                iter_reg <= plld_pkg::ITER_W'(plld_pkg::ROOT_W - 1);
            end
            else if (state_reg == plld_pkg::ST_ROOT)
            begin
                iter_reg <= iter_reg - 1'b1;
            end

            if (state_reg == plld_pkg::ST_ACCUM)
            begin
                // saturating path total
                total_reg  <= total_sum[plld_pkg::TOTAL_W] ? plld_pkg::TOTAL_MAX
                                                           : total_sum[plld_pkg::TOTAL_W-1:0];
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cur_x_reg <= pos_x;
            cur_y_reg <= pos_y;
            first_reg <= !started_reg;
        end

        case (state_reg)
            plld_pkg::ST_DIFF:
            begin
                if (term_reg == plld_pkg::TERM_THR)
                begin
                    op_reg <= plld_pkg::OP_W'(thr_reg);
                end
                else
                begin
                    op_reg <= diff_abs[plld_pkg::OP_W-1:0];
                end
            end
            plld_pkg::ST_SQUARE:
            begin
                prod_reg <= plld_pkg::PROD_W'(op_reg) * plld_pkg::PROD_W'(op_reg);
            end
            plld_pkg::ST_ADD:
            begin
                case (term_reg)
                    plld_pkg::TERM_THR:
                    begin
                        thr_sq_reg <= plld_pkg::THRSQ_W'(prod_reg);
                    end
                    plld_pkg::TERM_OX, plld_pkg::TERM_DX:
                    begin
                        acc_reg <= plld_pkg::SQ_W'(prod_reg);
                    end
                    plld_pkg::TERM_OY:
                    begin
                        acc_reg <= sq_sum;
                    end
                    default:
                    begin
                        // squared step ready, start the root
                        rad_reg  <= plld_pkg::RAD_W'(sq_sum);
                        rem_reg  <= '0;
                        root_reg <= '0;
                    end
                endcase
            end
            plld_pkg::ST_LAP:
            begin
                lap_reg <= (acc_reg < plld_pkg::SQ_W'(thr_sq_reg));
                if (first_reg)
                begin
                    root_reg <= '0;
                end
            end
            plld_pkg::ST_ROOT:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= root_bit ? (rem_cat - trial) : rem_cat;
                root_reg <= {root_reg[plld_pkg::ROOT_W-2:0], root_bit};
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            total_length_reg <= total_reg;
            step_length_reg  <= (root_ext > plld_pkg::ROOT_EXT_W'(plld_pkg::STEP_MAX))
                              ? plld_pkg::STEP_MAX : root_ext[plld_pkg::STEP_W-1:0];
            lap_closed_reg   <= lap_reg;
            first_sample_reg <= first_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign total_length = total_length_reg;
    assign step_length  = step_length_reg;
    assign lap_closed   = lap_closed_reg;
    assign first_sample = first_sample_reg;

`ifndef SYNTHESIS
    // an accepted item keeps the sequencer busy on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an item was taken");

    // a first sample adds no length
    a_first_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_sample) |-> (step_length == '0))
        else $error("first sample reports a nonzero step");

    // the start compared with itself closes the lap unless the threshold is zero
    a_first_lap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_sample) |-> (lap_closed == (thr_reg != '0)))
        else $error("first sample lap flag wrong");

    // the root runs only on items past the first
    a_root_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plld_pkg::ST_ROOT) |-> !first_reg)
        else $error("square root started on a first sample");
`endif

endmodule

/* tb/tb_path_length_and_lap_detector.sv */
`timescale 1ns / 1ps

module tb_path_length_and_lap_detector;

    localparam int CLK_PERIOD     = 10;
    localparam int SETTLE_CYCLES  = 50;    // a little over one full sample latency
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with nothing accepted on any channel
    localparam int PHASE_ITEMS    = 170;
    localparam int CEILING_ITEMS  = 230;
    localparam int N_ROWS         = 21;

    typedef logic signed [plld_pkg::COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_MAX = 24'sh7FFFFF;
    localparam coord_t COORD_MIN = 24'sh800000;

    // one result item as the block reports it
    typedef struct packed {
        logic [plld_pkg::TOTAL_W-1:0] total;
        logic [plld_pkg::STEP_W-1:0]  step;
        logic                         lap;
        logic                         first;
    } lap_report_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_THRESHOLD
    } row_kind_t;

    // one line of the directed plan: a sample or a threshold write
    typedef struct packed {
        row_kind_t                  kind;
        coord_t                     x;
        coord_t                     y;
        logic [plld_pkg::THR_W-1:0] thr;
        logic                       typed;  // use the hand-written result below
        lap_report_t                want;
    } plan_row_t;

    // block ports
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [plld_pkg::THR_W-1:0]     cfg_wr_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    coord_t                         pos_x = '0;
    coord_t                         pos_y = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [plld_pkg::TOTAL_W-1:0]   total_length;
    logic [plld_pkg::STEP_W-1:0]    step_length;
    logic                           lap_closed;
    logic                           first_sample;

    // odometry model state, mirrors the block after every accepted sample
    bit                             path_started = 1'b0;
    longint                         start_x = 0;
    longint                         start_y = 0;
    longint                         last_x = 0;
    longint                         last_y = 0;
    logic [plld_pkg::TOTAL_W-1:0]   path_sum = '0;
    logic [plld_pkg::THR_W-1:0]     lap_thr = plld_pkg::THR_RESET;

    // results owed by the block, oldest first
    lap_report_t                    pending_results[$];

    // idling control, percent chance per item (sender) or per cycle (receiver)
    int                             gap_pct = 0;
    int                             stall_pct = 0;
    int                             stall_left = 0;

    int                             n_errors = 0;
    int                             n_items = 0;
    int                             n_results = 0;
    int                             n_cfg_writes = 0;
    int                             idle_cycles = 0;
    longint unsigned                largest_step = 0;
    bit                             hit_ceiling = 1'b0;

    plan_row_t                      plan [N_ROWS];

    path_length_and_lap_detector dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .total_length (total_length),
        .step_length  (step_length),
        .lap_closed   (lap_closed),
        .first_sample (first_sample)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // squared euclidean distance of an offset, exact in 64 bits for 24-bit coordinates
    function automatic longint unsigned offset_sq(input longint dx, input longint dy);
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    // floor square root, one result bit at a time from the top
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 26; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // advance the odometry state by one sample and give the result it owes
    task automatic advance_odometry(input coord_t x, input coord_t y, output lap_report_t r);
        longint          sx;
        longint          sy;
        longint unsigned seg;
        longint unsigned sum;
        longint unsigned thr_sq;
        sx = x;
        sy = y;
        seg = 0;
        r.first = !path_started;
        if (!path_started)
        begin
            // first sample only latches the start point
            start_x = sx;
            start_y = sy;
            path_started = 1'b1;
        end
        else
        begin
            seg = floor_sqrt(offset_sq(sx - last_x, sy - last_y));
            sum = longint'(path_sum) + seg;
            // total saturates and then stays at the top
            path_sum = (sum > 64'hFFFF_FFFF) ? plld_pkg::TOTAL_MAX : 32'(sum);
            if (path_sum == plld_pkg::TOTAL_MAX)
                hit_ceiling = 1'b1;
            if (seg > largest_step)
                largest_step = seg;
        end
        last_x = sx;
        last_y = sy;
        thr_sq = longint'(lap_thr) * longint'(lap_thr);
        r.total = path_sum;
        r.step  = (seg > plld_pkg::STEP_MAX) ? plld_pkg::STEP_MAX : 25'(seg);
        // strict compare, so a zero threshold never closes a lap
        r.lap   = offset_sq(sx - start_x, sy - start_y) < thr_sq;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on result %0d, %s: got %0d expected %0d", n_results, what, got,
                 want);
        n_errors++;
    endtask

    // hand one sample over, with an optional random gap before it
    task automatic send_sample(input coord_t x, input coord_t y, input bit typed,
                               input lap_report_t typed_want);
        lap_report_t r;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= x;
        pos_y    <= y;
        do @(posedge clk); while (in_stall);
        advance_odometry(x, y, r);
        if (typed)
            r = typed_want;
        pending_results = {pending_results, r};
        n_items++;
    endtask

    // stop sending until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // threshold writes only happen with the block idle
    task automatic write_threshold(input logic [plld_pkg::THR_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        lap_thr = v;
        cfg_wr_en <= 1'b0;
        n_cfg_writes++;
    endtask

    // random position: mostly short walk steps and returns to the start,
    // some jumps anywhere and to the corners of the coordinate range
    task automatic pick_roaming_point(output coord_t x, output coord_t y);
        int unsigned roll;
        int          span;
        int          reach;
        roll = $urandom_range(99);
        if (roll < 62)
        begin
            span = 1 << $urandom_range(12, 0);
            x = coord_t'(last_x + (int'($urandom_range(2 * span)) - span));
            y = coord_t'(last_y + (int'($urandom_range(2 * span)) - span));
        end
        else if (roll < 82)
        begin
            // somewhere around the lap radius
            reach = int'(lap_thr) + 2;
            x = coord_t'(start_x + (int'($urandom_range(2 * reach)) - reach));
            y = coord_t'(start_y + (int'($urandom_range(2 * reach)) - reach));
        end
        else if (roll < 85)
        begin
            x = coord_t'(start_x);
            y = coord_t'(start_y);
        end
        else if (roll < 88)
        begin
            // right on the rim or just inside it
            x = coord_t'(start_x + int'(lap_thr) - int'($urandom_range(1)));
            y = coord_t'(start_y);
        end
        else if (roll < 95)
        begin
            x = coord_t'($urandom);
            y = coord_t'($urandom);
        end
        else
        begin
            x = $urandom_range(1) ? COORD_MAX : COORD_MIN;
            y = $urandom_range(1) ? COORD_MAX : COORD_MIN;
        end
    endtask

    // receiver side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            stall_left <= $urandom_range(11, 0);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // result checker, field by field against the oldest owed result
    always @(posedge clk)
    begin
        lap_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with none owed", 64'(total_length), '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (total_length !== want.total)
                    report_mismatch("total_length", 64'(total_length), 64'(want.total));
                if (step_length !== want.step)
                    report_mismatch("step_length", 64'(step_length), 64'(want.step));
                if (lap_closed !== want.lap)
                    report_mismatch("lap_closed", 64'(lap_closed), 64'(want.lap));
                if (first_sample !== want.first)
                    report_mismatch("first_sample", 64'(first_sample), 64'(want.first));
            end
            n_results++;
        end
    end

    // watchdog on cycles where no item moves on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        coord_t                     px;
        coord_t                     py;
        logic [plld_pkg::THR_W-1:0] thr;
        int                         jitter;

        // directed plan, hand-written results where they are easy to see
        plan = '{
            // reset threshold 100, the very first sample sets the start
            '{ROW_SAMPLE, 24'sd0, 24'sd0, 16'd0, 1'b1, '{32'd0, 25'd0, 1'b1, 1'b1}},
            '{ROW_SAMPLE, 24'sd3, 24'sd4, 16'd0, 1'b1, '{32'd5, 25'd5, 1'b1, 1'b0}},
            // exactly on the rim: not closed
            '{ROW_SAMPLE, 24'sd100, 24'sd0, 16'd0, 1'b1, '{32'd102, 25'd97, 1'b0, 1'b0}},
            '{ROW_SAMPLE, 24'sd99, 24'sd0, 16'd0, 1'b1, '{32'd103, 25'd1, 1'b1, 1'b0}},
            '{ROW_SAMPLE, 24'sd60, 24'sd80, 16'd0, 1'b1, '{32'd192, 25'd89, 1'b0, 1'b0}},
            '{ROW_SAMPLE, 24'sd0, 24'sd0, 16'd0, 1'b1, '{32'd292, 25'd100, 1'b1, 1'b0}},
            // zero threshold: never closed, even at the start
            '{ROW_THRESHOLD, 24'sd0, 24'sd0, 16'd0, 1'b0, '0},
            '{ROW_SAMPLE, 24'sd0, 24'sd0, 16'd0, 1'b1, '{32'd292, 25'd0, 1'b0, 1'b0}},
            '{ROW_SAMPLE, 24'sd1, 24'sd0, 16'd0, 1'b1, '{32'd293, 25'd1, 1'b0, 1'b0}},
            '{ROW_THRESHOLD, 24'sd0, 24'sd0, 16'd1, 1'b0, '0},
            '{ROW_SAMPLE, 24'sd0, 24'sd0, 16'd0, 1'b1, '{32'd294, 25'd1, 1'b1, 1'b0}},
            '{ROW_SAMPLE, 24'sd0, -24'sd1, 16'd0, 1'b1, '{32'd295, 25'd1, 1'b0, 1'b0}},
            // widest threshold, rim and just inside
            '{ROW_THRESHOLD, 24'sd0, 24'sd0, 16'd65535, 1'b0, '0},
            '{ROW_SAMPLE, 24'sd65535, 24'sd0, 16'd0, 1'b1,
              '{32'd65830, 25'd65535, 1'b0, 1'b0}},
            '{ROW_SAMPLE, 24'sd0, -24'sd65534, 16'd0, 1'b0, '0},
            // corners of the coordinate range with corner to corner steps, then two other points
            '{ROW_SAMPLE, 24'sh7FFFFF, 24'sh7FFFFF, 16'd0, 1'b0, '0},
            '{ROW_SAMPLE, 24'sh800000, 24'sh800000, 16'd0, 1'b0, '0},
            '{ROW_SAMPLE, 24'sh7FFFFF, 24'sh800000, 16'd0, 1'b0, '0},
            '{ROW_SAMPLE, 24'sh800000, 24'sh7FFFFF, 16'd0, 1'b0, '0},
            '{ROW_SAMPLE, -24'sd1, -24'sd1, 16'd0, 1'b0, '0},
            '{ROW_SAMPLE, 24'sh555555, 24'shAAAAAA, 16'd0, 1'b0, '0}
        };

        // reset once
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, light receiver stalls only
        stall_pct = 25;
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (plan[i].kind == ROW_THRESHOLD)
                write_threshold(plan[i].thr);
            else
                send_sample(plan[i].x, plan[i].y, plan[i].typed, plan[i].want);
        end

        // random phases, each under its own threshold and idling mix
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    thr = 16'($urandom);
                    gap_pct = 20;
                    stall_pct = 20;
                end
                1:
                begin
                    thr = 16'd0;
                    gap_pct = 0;
                    stall_pct = 0;
                end
                2:
                begin
                    thr = 16'd65535;
                    gap_pct = 40;
                    stall_pct = 40;
                end
                3:
                begin
                    thr = 16'($urandom_range(50, 1));
                    gap_pct = 10;
                    stall_pct = 30;
                end
                4:
                begin
                    thr = 16'($urandom);
                    gap_pct = 30;
                    stall_pct = 0;
                end
                default:
                begin
                    thr = plld_pkg::THR_RESET;
                    gap_pct = 5;
                    stall_pct = 50;
                end
            endcase
            write_threshold(thr);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // now and then hold off until the block has caught up
                if ($urandom_range(99) == 0)
                    drain_results();
                pick_roaming_point(px, py);
                send_sample(px, py, 1'b0, '0);
            end
        end

        // last part, no idling: corner to corner jumps push the total to its ceiling
        write_threshold(16'($urandom));
        gap_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < CEILING_ITEMS; i++)
        begin
            jitter = $urandom_range(1000);
            if (i % 2 == 0)
            begin
                px = COORD_MAX - coord_t'(jitter);
                py = COORD_MAX - coord_t'($urandom_range(1000));
            end
            else
            begin
                px = COORD_MIN + coord_t'(jitter);
                py = COORD_MIN + coord_t'($urandom_range(1000));
            end
            send_sample(px, py, 1'b0, '0);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("checked %0d results from %0d samples under %0d lap threshold settings",
                 n_results, n_items, n_cfg_writes + 1);
        $display("largest step %0d mm, path total %s its ceiling", largest_step,
                 hit_ceiling ? "reached" : "stayed below");
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/plld_pkg.sv
rtl/path_length_and_lap_detector.sv
tb/tb_path_length_and_lap_detector.sv
